// ===== design/ksr_pkg.sv =====
// ----------------------------------------------------------------------------
// ksr_pkg: shared types and constants for the keyboard scan responder
// Holds the op codes of the input channel, the command record that travels
// from the front end to the back end, and the scan timing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ksr_pkg;

  // Input op codes
  localparam logic [1:0] OP_STATUS = 2'd0;
  localparam logic [1:0] OP_KEY    = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Key bitmap geometry and scan constants
  localparam int          NKEYS             = 256;
  localparam int          CHUNK_W           = 16;
  localparam int          CHUNK_IDX_W       = 4;
  localparam logic [7:0]  BYTE_CLOCKS_RESET = 8'd160;
  localparam logic [8:0]  EMPTY_ADD         = 9'd127;
  localparam logic [7:0]  END_CODE          = 8'h7F;
  localparam logic [8:0]  POS_NONE          = 9'd256;
  localparam int          START_BIT         = 6;
  localparam int          BEEP_BIT          = 7;

  // Command queue depth between front and back
  localparam int          QUEUE_DEPTH       = 2;

  // Classified command kinds
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_STATUS,
    CMD_KEY,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  // Scan protocol state
  typedef enum logic [1:0] {
    RUN_IDLE,
    RUN_SENDING,
    RUN_RESPONDING
  } run_state_t;

  // Back end sequencing state
  typedef enum logic {
    BK_READY,
    BK_SEARCH
  } back_state_t;

endpackage

`default_nettype wire

// ===== design/ksr_front.sv =====
// ----------------------------------------------------------------------------
// ksr_front: input acceptance, classification and command queue
// Takes input items, turns each into a command kind plus data byte and
// holds them in a small queue until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module ksr_front #(
  parameter int QUEUE_DEPTH = ksr_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    op,
  input  logic [7:0]    data,
  input  logic          rising_edge,
  output logic          q_valid,
  output ksr_pkg::cmd_t q_cmd,
  input  logic          q_take
);
  import ksr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  cmd_t             in_cmd;

  // Classify the incoming item
  always_comb begin
    in_cmd.data = data;
    unique case (op)
      OP_STATUS: in_cmd.kind = CMD_STATUS;
      OP_KEY:    in_cmd.kind = CMD_KEY;
      OP_TICK:   in_cmd.kind = rising_edge ? CMD_TICK : CMD_NOP;
      default:   in_cmd.kind = CMD_NOP;
    endcase
  end

  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_cmd    = queue_mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_take && q_valid;

  // Store the command at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= in_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/ksr_back.sv =====
// ----------------------------------------------------------------------------
// ksr_back: scan engine and result register
// Executes queued commands against the key bitmaps and the scan protocol,
// runs the next-key search 16 keys per cycle, and registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

module ksr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    byte_clocks,
  input  logic          q_valid,
  input  ksr_pkg::cmd_t q_cmd,
  output logic          q_take,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          latch_strobe,
  output logic [7:0]    latch_value,
  output logic          beep
);
  import ksr_pkg::*;

  back_state_t            bk_state, bk_state_next;
  run_state_t             run_state, run_state_next;
  logic [8:0]             countdown, countdown_next;
  logic [NKEYS-1:0]       pending_keys, pending_keys_next;
  logic [NKEYS-1:0]       previous_keys, previous_keys_next;
  logic [NKEYS-1:0]       scan_rest, scan_rest_next;
  logic [CHUNK_IDX_W-1:0] chunk_idx, chunk_idx_next;
  logic [8:0]             scan_position, scan_position_next;
  logic                   search_merge, search_merge_next;
  logic [7:0]             latch_byte, latch_byte_next;
  logic                   out_valid_next;
  logic                   latch_strobe_next;
  logic                   beep_next;
  logic                   out_free;
  logic [CHUNK_W-1:0]     low_chunk;
  logic [8:0]             hit_pos;

  // Lowest set bit of a 16-bit chunk, split into two 8-bit halves
  function automatic logic [3:0] lowest_set(input logic [15:0] bits);
    logic       upper;
    logic [7:0] half;
    logic [2:0] idx;
    upper = (bits[7:0] == 8'd0);
    half  = upper ? bits[15:8] : bits[7:0];
    idx   = '0;
    for (int i = 7; i >= 0; i--) begin
      if (half[i]) begin
        idx = 3'(i);
      end
    end
    return {upper, idx};
  endfunction

  assign out_free  = !out_valid || out_ready;
  assign q_take    = q_valid && (bk_state == BK_READY) && out_free;
  assign low_chunk = scan_rest[CHUNK_W-1:0];

  // Next state: search step, or execute the head command
  always_comb begin
    bk_state_next      = bk_state;
    run_state_next     = run_state;
    countdown_next     = countdown;
    pending_keys_next  = pending_keys;
    previous_keys_next = previous_keys;
    scan_rest_next     = scan_rest;
    chunk_idx_next     = chunk_idx;
    scan_position_next = scan_position;
    search_merge_next  = search_merge;
    latch_byte_next    = latch_byte;
    out_valid_next     = out_valid && !out_ready;
    latch_strobe_next  = latch_strobe;
    beep_next          = beep;
    hit_pos            = POS_NONE;

    if (bk_state == BK_SEARCH) begin
      // Walk the merged bitmap one chunk per cycle
      if (low_chunk != '0) begin
        hit_pos = {1'b0, chunk_idx, lowest_set(low_chunk)};
      end
      if (low_chunk != '0 || chunk_idx == '1) begin
        scan_position_next = hit_pos;
        bk_state_next      = BK_READY;
        if (search_merge) begin
          countdown_next = {1'b0, byte_clocks} + (hit_pos[8] ? EMPTY_ADD : hit_pos);
        end
      end else begin
        scan_rest_next = scan_rest >> CHUNK_W;
        chunk_idx_next = chunk_idx + 1'b1;
      end
    end else if (q_take) begin
      out_valid_next    = 1'b1;
      latch_strobe_next = 1'b0;
      beep_next         = 1'b0;
      unique case (q_cmd.kind)
        CMD_STATUS: begin
          beep_next = q_cmd.data[BEEP_BIT];
          if (q_cmd.data[START_BIT] && run_state == RUN_IDLE) begin
            run_state_next = RUN_SENDING;
            countdown_next = {1'b0, byte_clocks};
          end
        end
        CMD_KEY: begin
          pending_keys_next[q_cmd.data] = 1'b1;
        end
        CMD_TICK: begin
          unique case (run_state)
            RUN_SENDING: begin
              if (countdown == '0) begin
                // Merge keys and start the first search
                scan_rest_next     = previous_keys | pending_keys;
                previous_keys_next = pending_keys;
                pending_keys_next  = '0;
                chunk_idx_next     = '0;
                search_merge_next  = 1'b1;
                bk_state_next      = BK_SEARCH;
                run_state_next     = RUN_RESPONDING;
              end else begin
                countdown_next = countdown - 1'b1;
              end
            end
            RUN_RESPONDING: begin
              if (countdown == '0) begin
                latch_strobe_next = 1'b1;
                if (!scan_position[8]) begin
                  // Deliver this key, drop it, look for the next one
                  countdown_next    = {1'b0, byte_clocks};
                  latch_byte_next   = scan_position[7:0];
                  scan_rest_next[8'(scan_position[CHUNK_IDX_W-1:0])] = 1'b0;
                  search_merge_next = 1'b0;
                  bk_state_next     = BK_SEARCH;
                end else begin
                  latch_byte_next = END_CODE;
                  run_state_next  = RUN_IDLE;
                end
              end else begin
                countdown_next = countdown - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Control and bitmap registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bk_state      <= BK_READY;
      run_state     <= RUN_IDLE;
      countdown     <= '0;
      pending_keys  <= '0;
      previous_keys <= '0;
      scan_position <= POS_NONE;
      latch_byte    <= '0;
      out_valid     <= 1'b0;
    end else begin
      bk_state      <= bk_state_next;
      run_state     <= run_state_next;
      countdown     <= countdown_next;
      pending_keys  <= pending_keys_next;
      previous_keys <= previous_keys_next;
      scan_position <= scan_position_next;
      latch_byte    <= latch_byte_next;
      out_valid     <= out_valid_next;
    end
  end

  // Search working registers and result payload
  always_ff @(posedge clk) begin
    scan_rest    <= scan_rest_next;
    chunk_idx    <= chunk_idx_next;
    search_merge <= search_merge_next;
    latch_strobe <= latch_strobe_next;
    beep         <= beep_next;
  end

  assign latch_value = latch_byte;

  // A search only runs while a scan is being answered
  a_search_in_scan: assert property (@(posedge clk) disable iff (rst)
    bk_state == BK_SEARCH |-> run_state == RUN_RESPONDING)
    else $error("search outside responding state");

  // Idle countdown is always cleared
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    run_state == RUN_IDLE |-> countdown == '0)
    else $error("countdown nonzero while idle");

  // An expiring responding tick strobes the latch
  a_strobe_on_expiry: assert property (@(posedge clk) disable iff (rst)
    q_take && q_cmd.kind == CMD_TICK && run_state == RUN_RESPONDING && countdown == '0
    |=> out_valid && latch_strobe)
    else $error("missing strobe on byte delivery");

  // The pending scan position sits in the current chunk and is still set
  a_position_tracks: assert property (@(posedge clk) disable iff (rst)
    bk_state == BK_READY && run_state == RUN_RESPONDING && !scan_position[8]
    |-> chunk_idx == scan_position[7:CHUNK_IDX_W]
        && low_chunk[scan_position[CHUNK_IDX_W-1:0]])
    else $error("scan position out of step with bitmap window");

endmodule

`default_nettype wire

// ===== design/keyboard_scan_responder_top.sv =====
// ----------------------------------------------------------------------------
// keyboard_scan_responder_top: emulated terminal keyboard scan responder
// Input channel (in_valid/in_ready) carries op, data and rising_edge: status
// writes, key presses and clock ticks. Every accepted item yields exactly one
// result on the output channel (out_valid/out_ready): latch_strobe,
// latch_value, tx_buffer_empty and beep. The cfg channel writes byte_clocks
// (ticks per delivered byte), and must only be used while the block is idle.
// Path: an accepted item is written into the command queue and from there
// into the output register. Throughput: one item per cycle while the
// receiver takes results, except that a tick that merges the key bitmaps or
// delivers a key starts the next-key search, which walks the 256-key bitmap
// 16 keys per cycle and holds the command queue until it ends. Items arriving
// meanwhile wait in the queue, and in_ready drops once it is full.
// Reset clears the pending and previous key bitmaps, the latch byte and the
// scan state at once and sets byte_clocks to 160; no clearing pass. A stalled
// receiver holds the result register; the queue keeps taking items until full.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_scan_responder_top #(
  parameter int QUEUE_DEPTH = ksr_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] data,
  input  logic       rising_edge,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       latch_strobe,
  output logic [7:0] latch_value,
  output logic       tx_buffer_empty,
  output logic       beep,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import ksr_pkg::*;

  logic       q_valid;
  cmd_t       q_cmd;
  logic       q_take;
  logic [7:0] byte_clocks;

  // Hold the byte time register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_clocks <= BYTE_CLOCKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      byte_clocks <= cfg_data;
    end
  end

  assign tx_buffer_empty = 1'b1;

  ksr_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .data        (data),
    .rising_edge (rising_edge),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_take      (q_take)
  );

  ksr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .byte_clocks  (byte_clocks),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_take       (q_take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .latch_strobe (latch_strobe),
    .latch_value  (latch_value),
    .beep         (beep)
  );

endmodule

`default_nettype wire
